@@ rtl/motor_drive_mode_sequencer_top_assert.svh @@
// Assertion macros for the mode sequencer.
`ifndef MOTOR_DRIVE_MODE_SEQUENCER_TOP_ASSERT_SVH
`define MOTOR_DRIVE_MODE_SEQUENCER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define MDMS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define MDMS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/mdms_pkg.sv @@
package mdms_pkg;

   localparam int ErrorWidth = 8;
   localparam int DelayWidth = 16;

   localparam logic [ErrorWidth-1:0] STICKY_ERR = 8'h80;
   localparam logic [DelayWidth-1:0] DELAY_RESET = 16'd200;

   localparam logic [2:0] MODE_BOOT = 3'd0;
   localparam logic [2:0] MODE_IDLE = 3'd1;
   localparam logic [2:0] MODE_RUN  = 3'd2;
   localparam logic [2:0] MODE_CAL  = 3'd3;
   localparam logic [2:0] MODE_ACOG = 3'd4;

   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_REQ    = 3'd1;
   localparam logic [2:0] OP_CLEAR  = 3'd2;
   localparam logic [2:0] OP_RAISE  = 3'd3;
   localparam logic [2:0] OP_CHECK  = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_ERRORS  = 2'd2;
   localparam logic [1:0] ST_CALINV  = 2'd3;

   typedef struct packed {
      logic [2:0]            opcode;
      logic                  calibration_valid;
      logic [ErrorWidth-1:0] raise_bits;
      logic [2:0]            target_mode;
   } req_type;

   typedef struct packed {
      logic [2:0]            left_mode;
      logic                  mode_entered;
      logic                  error_changed;
      logic [ErrorWidth-1:0] error_word;
      logic                  setpoint_hit;
      logic                  drive_on;
      logic                  bridge_armed;
      logic [1:0]            request_status;
      logic [2:0]            current_mode;
   } rsp_type;

endpackage

@@ rtl/motor_drive_mode_sequencer_top.sv @@
// channel | dir | handshake            | payload
// req     | in  | req_tvalid/tready    | tuser: opcode; tdata: target, raise bits, cal valid
// rsp     | out | rsp_tvalid/tready    | tdata: mode, status, flags, errors, entry info
// csr     | in  | csr_wr_en            | csr_wr_data: charge_delay_ticks
//
// One beat per cycle sustained while rsp_tready is high; a result is valid from the result register.
// Input register -> single combinational state update -> result register.
// The input register still takes one beat while a result is stalled downstream.
// Synchronous active-high reset clears mode state, errors and both valids.
module motor_drive_mode_sequencer_top
   import mdms_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [DelayWidth-1:0] csr_wr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,  // target_mode, raise_bits, calibration_valid
   input  logic [2:0]            req_tuser,  // opcode
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata   // current_mode, request_status, bridge_armed,
                                             // drive_on, setpoint_hit, error_word,
                                             // error_changed, mode_entered, left_mode
);

   logic [DelayWidth-1:0] delay_ff;
   logic                  in_valid_ff, in_valid_in;
   req_type               in_ff;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;

   logic [2:0]            mode_ff, mode_in;
   logic [2:0]            pending_ff, pending_in;
   logic                  exit_ready_ff, exit_ready_in;
   logic [DelayWidth-1:0] countdown_ff, countdown_in;
   logic [ErrorWidth-1:0] errors_ff, errors_in;
   logic [ErrorWidth-1:0] reported_ff, reported_in;
   logic                  armed_ff, armed_in;
   logic [1:0]            run_bits_ff, run_bits_in;

   logic advance;
   logic fire;
   logic do_req;
   logic [2:0] req_target;
   logic [1:0] req_status;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign fire       = in_valid_ff && advance;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   always_comb begin
      mode_in       = mode_ff;
      pending_in    = pending_ff;
      exit_ready_in = exit_ready_ff;
      countdown_in  = countdown_ff;
      errors_in     = errors_ff;
      reported_in   = reported_ff;
      armed_in      = armed_ff;
      run_bits_in   = run_bits_ff;
      out_in        = '0;
      req_status    = ST_OK;
      do_req        = 1'b0;
      req_target    = in_ff.target_mode;

      case (in_ff.opcode)
         OP_TICK: begin
            if (pending_ff != mode_ff) begin
               case (mode_ff)
                  MODE_IDLE: begin
                     if (countdown_ff != '0) begin
                        countdown_in = countdown_ff - 1'b1;
                     end else begin
                        exit_ready_in = 1'b1;
                     end
                  end
                  MODE_RUN: begin
                     armed_in      = 1'b0;
                     run_bits_in   = 2'b00;
                     exit_ready_in = 1'b1;
                  end
                  default: begin
                     exit_ready_in = 1'b1;
                  end
               endcase
               if (exit_ready_in) begin
                  out_in.left_mode    = mode_ff;
                  out_in.mode_entered = 1'b1;
                  mode_in             = pending_ff;
                  if (pending_ff == MODE_RUN) begin
                     run_bits_in = 2'b11;
                  end
               end
            end
         end
         OP_REQ: begin
            do_req = 1'b1;
         end
         OP_CLEAR: begin
            errors_in   = errors_ff & STICKY_ERR;
            reported_in = reported_ff & STICKY_ERR;
         end
         OP_RAISE: begin
            errors_in = errors_ff | in_ff.raise_bits;
         end
         OP_CHECK: begin
            if (reported_ff != errors_ff) begin
               if (errors_ff != '0) begin
                  armed_in   = 1'b0;
                  do_req     = 1'b1;
                  req_target = MODE_IDLE;
               end
               out_in.error_changed = 1'b1;
               reported_in          = errors_ff;
            end
         end
         default: begin
         end
      endcase

      if (do_req) begin
         exit_ready_in = 1'b0;
         if (mode_ff == MODE_IDLE) begin
            if (req_target == MODE_IDLE) begin
               armed_in     = 1'b0;
               countdown_in = '0;
               pending_in   = MODE_IDLE;
            end else if (req_target == MODE_RUN || req_target == MODE_CAL ||
                         req_target == MODE_ACOG) begin
               if (errors_ff != '0) begin
                  req_status = ST_ERRORS;
               end else if (req_target != MODE_CAL && !in_ff.calibration_valid) begin
                  req_status = ST_CALINV;
               end else begin
                  armed_in     = 1'b1;
                  countdown_in = delay_ff;
                  pending_in   = req_target;
               end
            end else begin
               req_status = ST_INVALID;
            end
         end else begin
            if (req_target == MODE_IDLE) begin
               pending_in = MODE_IDLE;
            end else begin
               req_status = ST_INVALID;
            end
         end
      end

      out_in.current_mode   = mode_in;
      out_in.request_status = (in_ff.opcode == OP_REQ) ? req_status : ST_OK;
      out_in.bridge_armed   = armed_in;
      out_in.drive_on       = run_bits_in[0];
      out_in.setpoint_hit   = run_bits_in[1];
      out_in.error_word     = errors_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff      <= DELAY_RESET;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         mode_ff       <= MODE_BOOT;
         pending_ff    <= MODE_BOOT;
         exit_ready_ff <= 1'b0;
         countdown_ff  <= '0;
         errors_ff     <= '0;
         reported_ff   <= '0;
         armed_ff      <= 1'b0;
         run_bits_ff   <= 2'b00;
      end else begin
         if (csr_wr_en) begin
            delay_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (fire) begin
            mode_ff       <= mode_in;
            pending_ff    <= pending_in;
            exit_ready_ff <= exit_ready_in;
            countdown_ff  <= countdown_in;
            errors_ff     <= errors_in;
            reported_ff   <= reported_in;
            armed_ff      <= armed_in;
            run_bits_ff   <= run_bits_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_ff.opcode            <= req_tuser;
         in_ff.target_mode       <= req_tdata[2:0];
         in_ff.raise_bits        <= req_tdata[10:3];
         in_ff.calibration_valid <= req_tdata[11];
      end
      if (fire) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff};

   `include "motor_drive_mode_sequencer_top_assert.svh"

   `MDMS_ASSERT_NOW(a_entered_changes_mode, out_valid_ff && out_ff.mode_entered,
      out_ff.left_mode != out_ff.current_mode, "entry beat without a mode change")
   `MDMS_ASSERT_NOW(a_left_zero, out_valid_ff && !out_ff.mode_entered,
      out_ff.left_mode == MODE_BOOT, "left_mode set without an entry")
   `MDMS_ASSERT_NOW(a_run_bits_only_in_run, run_bits_ff != 2'b00,
      mode_ff == MODE_RUN, "run status bits set outside run")
   `MDMS_ASSERT_NEXT(a_stalled_input_kept, in_valid_ff && !advance,
      in_valid_ff, "input beat dropped while stalled")

endmodule
